### hdl/itd_pkg.sv
`timescale 1ns / 1ps

package itd_pkg;

    // field widths
    localparam int WORD_W = 64;
    localparam int TYPE_W = 3;
    localparam int CHAR_W = 8;

    // most digits one number may produce
    localparam int MAX_DIGITS = 20;

    // bcd register: enough digits for any 64-bit magnitude
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // counters
    localparam int BITCNT_W = $clog2(WORD_W + 1);
    localparam int DIGCNT_W = $clog2(BCD_DIGITS + 1);

    // element type codes
    localparam logic [TYPE_W-1:0] TYPE_INT8   = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_UINT8  = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_INT16  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_UINT16 = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_INT32  = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_UINT32 = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_INT64  = 3'd6;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // converted number handed from the converter to the emitter
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             neg;
    } conv_result_t;

endpackage

### hdl/integer_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Decimal text of an integer. Each request on the s_ side is a raw 64-bit
// word; the element type register (cfg_wr_en / cfg_wr_data, reset int64,
// code 7 read as int64) picks which low bits form the integer and whether
// they are signed. The text leaves on the m_ side one ASCII character per
// beat: an optional '-', then the digits with no leading zeros, tlast on
// the final one; zero gives "0". Timing: the binary-to-BCD converter shifts
// in the magnitude of the element type one bit per cycle, then hands the
// result over. The emitter then drops up to 19 leading zeros at one digit
// per cycle and sends one character per cycle while m_tready is high.
// Converter and emitter overlap, so the next word converts while the
// previous text drains. Write the type register only while the block is
// idle.
module integer_to_decimal_ascii (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: element type
    input  logic                        cfg_wr_en,
    input  logic [itd_pkg::TYPE_W-1:0]  cfg_wr_data,
    // input words
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [itd_pkg::WORD_W-1:0]  s_tdata,   // [63:0] raw_word
    // output characters
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [itd_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] text_char
    output logic                        m_tlast    // last_char
);
    import itd_pkg::*;

    logic [TYPE_W-1:0] element_type_reg;
    logic              conv_valid;
    logic              conv_ready;
    conv_result_t      conv_result;

    // element type register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_type_reg <= TYPE_INT64;
        end else if (cfg_wr_en) begin
            element_type_reg <= cfg_wr_data;
        end
    end

    // binary to bcd, one bit per cycle
    itd_bcd_conv u_conv (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .element_type (element_type_reg),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_word       (s_tdata),
        .conv_valid   (conv_valid),
        .conv_ready   (conv_ready),
        .conv_result  (conv_result)
    );

    // character emitter with output register
    itd_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .conv_valid  (conv_valid),
        .conv_ready  (conv_ready),
        .conv_result (conv_result),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### hdl/itd_bcd_conv.sv
`timescale 1ns / 1ps

module itd_bcd_conv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [itd_pkg::TYPE_W-1:0]  element_type,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [itd_pkg::WORD_W-1:0]  s_word,
    output logic                        conv_valid,
    input  logic                        conv_ready,
    output itd_pkg::conv_result_t       conv_result
);
    import itd_pkg::*;

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } cv_state_t;

    cv_state_t            state_reg, state_next;
    logic [WORD_W-1:0]    mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BITCNT_W-1:0]  cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;

    logic [WORD_W-1:0]    neg_word;
    logic                 start_neg;
    logic [WORD_W-1:0]    start_mag;
    logic [BITCNT_W-1:0]  start_bits;
    logic [BCD_W-1:0]     bcd_adj;
    logic                 sat;
    logic [BCD_W-1:0]     nines;

    // sign, magnitude and bit count per element type, magnitude left aligned
    always_comb begin
        neg_word   = '0 - s_word;
        start_neg  = 1'b0;
        start_mag  = '0;
        start_bits = BITCNT_W'(64);
        unique case (element_type)
            TYPE_INT8: begin
                start_neg  = s_word[7];
                start_mag  = {(s_word[7] ? neg_word[7:0] : s_word[7:0]), 56'd0};
                start_bits = BITCNT_W'(8);
            end
            TYPE_UINT8: begin
                start_mag  = {s_word[7:0], 56'd0};
                start_bits = BITCNT_W'(8);
            end
            TYPE_INT16: begin
                start_neg  = s_word[15];
                start_mag  = {(s_word[15] ? neg_word[15:0] : s_word[15:0]), 48'd0};
                start_bits = BITCNT_W'(16);
            end
            TYPE_UINT16: begin
                start_mag  = {s_word[15:0], 48'd0};
                start_bits = BITCNT_W'(16);
            end
            TYPE_INT32: begin
                start_neg  = s_word[31];
                start_mag  = {(s_word[31] ? neg_word[31:0] : s_word[31:0]), 32'd0};
                start_bits = BITCNT_W'(32);
            end
            TYPE_UINT32: begin
                start_mag  = {s_word[31:0], 32'd0};
                start_bits = BITCNT_W'(32);
            end
            default: begin
                // int64, and the unused code read as int64
                start_neg  = s_word[63];
                start_mag  = s_word[63] ? neg_word : s_word;
                start_bits = BITCNT_W'(64);
            end
        endcase
    end

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    // saturation when digits beyond the limit are present
    always_comb begin
        sat   = 1'b0;
        nines = '0;
        for (int i = MAX_DIGITS; i < BCD_DIGITS; i++) begin
            sat = sat | (bcd_reg[4*i +: 4] != 4'd0);
        end
        for (int i = 0; i < MAX_DIGITS; i++) begin
            nines[4*i +: 4] = 4'd9;
        end
    end

    // sequencer: one magnitude bit per cycle into the bcd register
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            CV_IDLE: begin
                if (s_valid) begin
                    mag_next   = start_mag;
                    bcd_next   = '0;
                    cnt_next   = start_bits;
                    neg_next   = start_neg;
                    state_next = CV_RUN;
                end
            end
            CV_RUN: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[WORD_W-1]};
                mag_next = {mag_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg - BITCNT_W'(1);
                if (cnt_reg == BITCNT_W'(1)) begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE: begin
                if (conv_ready) begin
                    state_next = CV_IDLE;
                end
            end
            default: begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign s_ready         = (state_reg == CV_IDLE);
    assign conv_valid      = (state_reg == CV_DONE);
    assign conv_result.bcd = sat ? nines : bcd_reg;
    assign conv_result.neg = neg_reg;

    // an accepted request always starts a conversion
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == CV_RUN)
        else $error("conversion did not start");

    // the bit counter never runs dry while converting
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == CV_RUN |-> cnt_reg != '0)
        else $error("bit counter empty while converting");

    // a finished result holds until the emitter takes it
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_valid && !conv_ready |=> conv_valid && $stable(bcd_reg) && $stable(neg_reg))
        else $error("converted result changed before handoff");

endmodule

### hdl/itd_emit.sv
`timescale 1ns / 1ps

module itd_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        conv_valid,
    output logic                        conv_ready,
    input  itd_pkg::conv_result_t       conv_result,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [itd_pkg::CHAR_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import itd_pkg::*;

    typedef enum logic [3:0] {
        EM_IDLE  = 4'b0001,
        EM_SKIP  = 4'b0010,
        EM_SIGN  = 4'b0100,
        EM_DIGIT = 4'b1000
    } em_state_t;

    em_state_t            state_reg, state_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [DIGCNT_W-1:0]  cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 valid_reg, valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic [3:0]           top_digit;
    logic                 out_free;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !valid_reg || m_tready;

    // skip leading zeros, then sign, then one digit per cycle while the output is free
    always_comb begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            EM_IDLE: begin
                if (conv_valid) begin
                    bcd_next   = conv_result.bcd;
                    neg_next   = conv_result.neg;
                    cnt_next   = DIGCNT_W'(BCD_DIGITS);
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP: begin
                if (top_digit == 4'd0 && cnt_reg != DIGCNT_W'(1)) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - DIGCNT_W'(1);
                end else if (neg_reg) begin
                    state_next = EM_SIGN;
                end else begin
                    state_next = EM_DIGIT;
                end
            end
            EM_SIGN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = ASCII_ZERO | {4'd0, top_digit};
                    last_next  = (cnt_reg == DIGCNT_W'(1));
                    bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next   = cnt_reg - DIGCNT_W'(1);
                    if (cnt_reg == DIGCNT_W'(1)) begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign conv_ready = (state_reg == EM_IDLE);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = char_reg;
    assign m_tlast    = last_reg;

    // digit count stays in range while a number is in flight
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EM_SKIP || state_reg == EM_DIGIT) |-> cnt_reg != '0)
        else $error("digit counter empty while emitting");

    // the final character returns the emitter to idle
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == EM_DIGIT && out_free && cnt_reg == DIGCNT_W'(1)
        |=> state_reg == EM_IDLE && m_tvalid && m_tlast)
        else $error("final character not flagged");

    // a sign is never the final character
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == ASCII_MINUS |-> !m_tlast)
        else $error("minus sign flagged as last");

endmodule
